// File: rtl/ptc_pkg.sv
package ptc_pkg;

  localparam int CORDIC_STAGES_DEF = 28;
  localparam int ANGLE_FRAC_BITS   = 27;
  localparam int NLANES            = 4;

  // Lanes of the CORDIC row.
  localparam int LANE_PLACE = 0;
  localparam int LANE_ROLL  = 1;
  localparam int LANE_PITCH = 2;
  localparam int LANE_YAW   = 3;

  // Register indexes on the configuration port.
  localparam logic REG_THICK = 1'b0;
  localparam logic REG_CLR   = 1'b1;

  localparam logic [20:0] THICK_RESET = 21'd104858;
  localparam logic [16:0] CLR_RESET   = 17'd3277;

  // Angle constants with ANGLE_FRAC_BITS fraction bits.
  localparam logic signed [35:0] PI_A      = 36'sd421657428;
  localparam logic signed [35:0] TWO_PI_A  = 36'sd843314857;
  localparam logic signed [35:0] HALF_PI_A = 36'sd210828714;

  localparam logic signed [32:0] GAIN_Q30 = 33'sd652032874;
  localparam logic signed [31:0] ONE_Q30  = 32'sd1073741824;

  typedef logic signed [31:0] ptc_word_t;

  typedef struct packed {
    logic               bottom;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] off_x;
    logic signed [31:0] off_y;
    logic signed [33:0] off_z;
  } ptc_side_t;

  typedef struct packed {
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [31:0] z;
    logic               neg;
  } ptc_lane_t;

  typedef struct packed {
    ptc_word_t [8:0] m;
    ptc_word_t [2:0] c;
    ptc_word_t [2:0] s;
    ptc_word_t [2:0] t;
  } ptc_mat_t;

  // Arctangent of 2^-i, rounded to nearest at ANGLE_FRAC_BITS.
  function automatic ptc_word_t atan_entry(input int i);
    ptc_word_t v;
    case (i)
      0:       v = 32'sd105414357;
      1:       v = 32'sd62229729;
      2:       v = 32'sd32880480;
      3:       v = 32'sd16690645;
      4:       v = 32'sd8377711;
      5:       v = 32'sd4192939;
      6:       v = 32'sd2096981;
      7:       v = 32'sd1048555;
      8:       v = 32'sd524285;
      9:       v = 32'sd262144;
      default: begin
        if (i <= ANGLE_FRAC_BITS) v = 32'sd1 <<< (ANGLE_FRAC_BITS - i);
        else if (i == ANGLE_FRAC_BITS + 1) v = 32'sd1;
        else v = 32'sd0;
      end
    endcase
    return v;
  endfunction

  // Q60 sum to Q30, rounded half up and clamped to plus or minus one.
  function automatic ptc_word_t rnd_clamp(input logic signed [64:0] acc);
    logic signed [64:0] t;
    ptc_word_t r;
    t = (acc + 65'sd536870912) >>> 30;
    if (t > 65'sd1073741824) r = ONE_Q30;
    else if (t < -65'sd1073741824) r = -ONE_Q30;
    else r = t[31:0];
    return r;
  endfunction

endpackage

// File: rtl/ptc_angle_prep.sv
module ptc_angle_prep (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  input  logic signed [ptc_pkg::NLANES-1:0][33:0] in_angle,
  input  ptc_pkg::ptc_side_t                     in_side,
  output logic                                   out_valid,
  output ptc_pkg::ptc_lane_t [ptc_pkg::NLANES-1:0] out_lane,
  output ptc_pkg::ptc_side_t                     out_side
);
  import ptc_pkg::*;

  logic signed [35:0] u0 [NLANES];
  logic signed [35:0] u1 [NLANES];
  logic signed [35:0] u2 [NLANES];
  logic [30:0]        md_nxt [NLANES];
  logic [30:0]        md_r   [NLANES];
  logic signed [35:0] r0 [NLANES];
  logic signed [35:0] r1 [NLANES];
  logic signed [35:0] r2 [NLANES];
  logic               neg_w [NLANES];
  ptc_lane_t [NLANES-1:0] lane_nxt;
  ptc_lane_t [NLANES-1:0] lane_r;
  ptc_side_t side1_r, side2_r;
  logic valid1_r, valid2_r;

  // First stage: shift the angle positive and take off four and two turns.
  always_comb begin
    for (int l = 0; l < NLANES; l++) begin
      u0[l] = 36'($signed(in_angle[l])) + 36'sd3 * TWO_PI_A;
      u1[l] = (u0[l] >= 36'sd4 * TWO_PI_A) ? u0[l] - 36'sd4 * TWO_PI_A : u0[l];
      u2[l] = (u1[l] >= 36'sd2 * TWO_PI_A) ? u1[l] - 36'sd2 * TWO_PI_A : u1[l];
      md_nxt[l] = u2[l][30:0];
    end
  end

  // Second stage: last turn, centre on zero and fold into the right half plane.
  always_comb begin
    for (int l = 0; l < NLANES; l++) begin
      r0[l] = {5'b0, md_r[l]};
      if (r0[l] >= TWO_PI_A) r0[l] = r0[l] - TWO_PI_A;
      r1[l] = (r0[l] > PI_A) ? r0[l] - TWO_PI_A : r0[l];
      neg_w[l] = 1'b0;
      r2[l] = r1[l];
      if (r1[l] > HALF_PI_A) begin
        r2[l] = r1[l] - PI_A;
        neg_w[l] = 1'b1;
      end else if (r1[l] < -HALF_PI_A) begin
        r2[l] = r1[l] + PI_A;
        neg_w[l] = 1'b1;
      end
      lane_nxt[l].x   = GAIN_Q30;
      lane_nxt[l].y   = '0;
      lane_nxt[l].z   = r2[l][31:0];
      lane_nxt[l].neg = neg_w[l];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r <= 1'b0;
      valid2_r <= 1'b0;
    end else begin
      valid1_r <= in_valid;
      valid2_r <= valid1_r;
    end
  end

  always_ff @(posedge clk) begin
    md_r    <= md_nxt;
    side1_r <= in_side;
    lane_r  <= lane_nxt;
    side2_r <= side1_r;
  end

  assign out_valid = valid2_r;
  assign out_lane  = lane_r;
  assign out_side  = side2_r;

endmodule

// File: rtl/ptc_cordic_cell.sv
module ptc_cordic_cell #(
  parameter int STAGE_IDX = 0
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  input  ptc_pkg::ptc_lane_t [ptc_pkg::NLANES-1:0] in_lane,
  input  ptc_pkg::ptc_side_t                      in_side,
  output logic                                    out_valid,
  output ptc_pkg::ptc_lane_t [ptc_pkg::NLANES-1:0] out_lane,
  output ptc_pkg::ptc_side_t                      out_side
);
  import ptc_pkg::*;

  localparam ptc_word_t ATAN = atan_entry(STAGE_IDX);

  logic signed [32:0] dx [NLANES];
  logic signed [32:0] dy [NLANES];
  ptc_lane_t [NLANES-1:0] lane_nxt;
  ptc_lane_t [NLANES-1:0] lane_r;
  ptc_side_t side_r;
  logic valid_r;

  always_comb begin
    for (int l = 0; l < NLANES; l++) begin
      dx[l] = $signed(in_lane[l].y) >>> STAGE_IDX;
      dy[l] = $signed(in_lane[l].x) >>> STAGE_IDX;
      lane_nxt[l].neg = in_lane[l].neg;
      if (!in_lane[l].z[31]) begin
        lane_nxt[l].x = $signed(in_lane[l].x) - dx[l];
        lane_nxt[l].y = $signed(in_lane[l].y) + dy[l];
        lane_nxt[l].z = $signed(in_lane[l].z) - ATAN;
      end else begin
        lane_nxt[l].x = $signed(in_lane[l].x) + dx[l];
        lane_nxt[l].y = $signed(in_lane[l].y) - dy[l];
        lane_nxt[l].z = $signed(in_lane[l].z) + ATAN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    lane_r <= lane_nxt;
    side_r <= in_side;
  end

  assign out_valid = valid_r;
  assign out_lane  = lane_r;
  assign out_side  = side_r;

endmodule

// File: rtl/ptc_col_rot.sv
module ptc_col_rot #(
  parameter int COL_A = 0,
  parameter int COL_B = 1,
  parameter int LANE  = 0,
  parameter bit NEG_S = 1'b0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  ptc_pkg::ptc_mat_t in_mat,
  output logic              out_valid,
  output ptc_pkg::ptc_mat_t out_mat
);
  import ptc_pkg::*;

  ptc_word_t cv, sv;
  ptc_word_t av [3];
  ptc_word_t bv [3];
  logic signed [63:0] pac_nxt [3];
  logic signed [63:0] pbs_nxt [3];
  logic signed [63:0] pbc_nxt [3];
  logic signed [63:0] pas_nxt [3];
  logic signed [63:0] pac_r [3];
  logic signed [63:0] pbs_r [3];
  logic signed [63:0] pbc_r [3];
  logic signed [63:0] pas_r [3];
  logic signed [64:0] sum_p [3];
  logic signed [64:0] sum_q [3];
  ptc_mat_t mat1_r, mat_nxt, mat2_r;
  logic valid1_r, valid2_r;

  // Columns a and b of every row turn by the lane's angle.
  always_comb begin
    cv = in_mat.c[LANE];
    sv = NEG_S ? -$signed(in_mat.s[LANE]) : $signed(in_mat.s[LANE]);
    for (int r = 0; r < 3; r++) begin
      av[r] = in_mat.m[3 * r + COL_A];
      bv[r] = in_mat.m[3 * r + COL_B];
      pac_nxt[r] = av[r] * cv;
      pbs_nxt[r] = bv[r] * sv;
      pbc_nxt[r] = bv[r] * cv;
      pas_nxt[r] = av[r] * sv;
    end
  end

  always_comb begin
    mat_nxt = mat1_r;
    for (int r = 0; r < 3; r++) begin
      sum_p[r] = 65'(pac_r[r]) + 65'(pbs_r[r]);
      sum_q[r] = 65'(pbc_r[r]) - 65'(pas_r[r]);
      mat_nxt.m[3 * r + COL_A] = rnd_clamp(sum_p[r]);
      mat_nxt.m[3 * r + COL_B] = rnd_clamp(sum_q[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r <= 1'b0;
      valid2_r <= 1'b0;
    end else begin
      valid1_r <= in_valid;
      valid2_r <= valid1_r;
    end
  end

  always_ff @(posedge clk) begin
    mat1_r <= in_mat;
    pac_r  <= pac_nxt;
    pbs_r  <= pbs_nxt;
    pbc_r  <= pbc_nxt;
    pas_r  <= pas_nxt;
    mat2_r <= mat_nxt;
  end

  assign out_valid = valid2_r;
  assign out_mat   = mat2_r;

endmodule

// File: rtl/placement_transform_compose.sv
// A start request is taken into the input register, then passes the angle reduction, the
// CORDIC row (one cell per stage), the placement rotation with translation and three column
// rotation stages before out_valid rises; one request is taken every cycle. busy is always low.
// Synchronous reset empties the pipeline and loads the register defaults.
// Results are strobed for one cycle and the receiver cannot stall them.
module placement_transform_compose #(
  parameter int CORDIC_STAGES = ptc_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_bottom_side,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_place_angle,
  input  logic signed [31:0] in_off_x,
  input  logic signed [31:0] in_off_y,
  input  logic signed [31:0] in_off_z,
  input  logic signed [31:0] in_roll_angle,
  input  logic signed [31:0] in_pitch_angle,
  input  logic signed [31:0] in_yaw_angle,
  output logic               out_valid,
  output logic signed [31:0] out_m_r1c1,
  output logic signed [31:0] out_m_r1c2,
  output logic signed [31:0] out_m_r1c3,
  output logic signed [31:0] out_m_r1c4,
  output logic signed [31:0] out_m_r2c1,
  output logic signed [31:0] out_m_r2c2,
  output logic signed [31:0] out_m_r2c3,
  output logic signed [31:0] out_m_r2c4,
  output logic signed [31:0] out_m_r3c1,
  output logic signed [31:0] out_m_r3c2,
  output logic signed [31:0] out_m_r3c3,
  output logic signed [31:0] out_m_r3c4,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import ptc_pkg::*;

  function automatic ptc_word_t clamp_unit(input logic signed [32:0] v);
    ptc_word_t r;
    if (v > 33'sd1073741824) r = ONE_Q30;
    else if (v < -33'sd1073741824) r = -ONE_Q30;
    else r = v[31:0];
    return r;
  endfunction

  function automatic ptc_word_t sat32(input logic signed [64:0] v);
    ptc_word_t r;
    if (v > 65'sd2147483647) r = 32'sh7fffffff;
    else if (v < -65'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // Configuration registers.
  logic [20:0] thick_r;
  logic [16:0] clr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thick_r <= THICK_RESET;
      clr_r   <= CLR_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_THICK: thick_r <= pwdata[20:0];
        REG_CLR:   clr_r   <= pwdata[16:0];
        default:   thick_r <= thick_r;
      endcase
    end
  end

  assign prdata = (paddr[2] == REG_CLR) ? {15'b0, clr_r} : {11'b0, thick_r};
  assign pready = 1'b1;
  assign busy   = 1'b0;

  // Input stage: tilt angles negated, placement angle plus pi on the bottom side, and the lifted z offset.
  logic signed [NLANES-1:0][33:0] ang_nxt, ang_r;
  ptc_side_t side_nxt, side_r;
  logic valid_in_r;

  always_comb begin
    ang_nxt[LANE_PLACE] = 34'(in_place_angle) + (in_bottom_side ? PI_A[33:0] : 34'sd0);
    ang_nxt[LANE_ROLL]  = -34'(in_roll_angle);
    ang_nxt[LANE_PITCH] = -34'(in_pitch_angle);
    ang_nxt[LANE_YAW]   = -34'(in_yaw_angle);
    side_nxt.bottom = in_bottom_side;
    side_nxt.pos_x  = in_pos_x;
    side_nxt.pos_y  = in_pos_y;
    side_nxt.off_x  = in_off_x;
    side_nxt.off_y  = in_off_y;
    side_nxt.off_z  = 34'(in_off_z) + $signed({17'b0, clr_r})
                    + (in_bottom_side ? 34'sd0 : $signed({13'b0, thick_r}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_in_r <= 1'b0;
    end else begin
      valid_in_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    ang_r  <= ang_nxt;
    side_r <= side_nxt;
  end

  // Angle reduction and the CORDIC row.
  logic                   cv [CORDIC_STAGES+1];
  ptc_lane_t [NLANES-1:0] cl [CORDIC_STAGES+1];
  ptc_side_t              cs [CORDIC_STAGES+1];

  ptc_angle_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (valid_in_r),
    .in_angle (ang_r),
    .in_side  (side_r),
    .out_valid(cv[0]),
    .out_lane (cl[0]),
    .out_side (cs[0])
  );

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    ptc_cordic_cell #(.STAGE_IDX(g)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (cv[g]),
      .in_lane  (cl[g]),
      .in_side  (cs[g]),
      .out_valid(cv[g+1]),
      .out_lane (cl[g+1]),
      .out_side (cs[g+1])
    );
  end

  // Placement rotation with the bottom flip folded in.
  ptc_word_t cw [NLANES];
  ptc_word_t sw [NLANES];
  ptc_word_t xc [NLANES];
  ptc_word_t yc [NLANES];
  ptc_mat_t  d1_nxt, d1_mat_r, d2_mat_r, d3_nxt, d3_mat_r;
  ptc_side_t d1_side_r, d2_side_r;
  logic      d1_valid_r, d2_valid_r, d3_valid_r;
  logic signed [63:0] p_nxt [4];
  logic signed [63:0] p_r   [4];
  logic signed [64:0] acc0, acc1, rnd0, rnd1;

  always_comb begin
    for (int l = 0; l < NLANES; l++) begin
      xc[l] = clamp_unit(cl[CORDIC_STAGES][l].x);
      yc[l] = clamp_unit(cl[CORDIC_STAGES][l].y);
      cw[l] = cl[CORDIC_STAGES][l].neg ? -xc[l] : xc[l];
      sw[l] = cl[CORDIC_STAGES][l].neg ? -yc[l] : yc[l];
    end
    d1_nxt      = '0;
    d1_nxt.m[0] = cw[LANE_PLACE];
    d1_nxt.m[1] = cs[CORDIC_STAGES].bottom ? sw[LANE_PLACE] : -sw[LANE_PLACE];
    d1_nxt.m[3] = sw[LANE_PLACE];
    d1_nxt.m[4] = cs[CORDIC_STAGES].bottom ? -cw[LANE_PLACE] : cw[LANE_PLACE];
    d1_nxt.m[8] = cs[CORDIC_STAGES].bottom ? -ONE_Q30 : ONE_Q30;
    d1_nxt.c[0] = cw[LANE_ROLL];
    d1_nxt.c[1] = cw[LANE_PITCH];
    d1_nxt.c[2] = cw[LANE_YAW];
    d1_nxt.s[0] = sw[LANE_ROLL];
    d1_nxt.s[1] = sw[LANE_PITCH];
    d1_nxt.s[2] = sw[LANE_YAW];
  end

  always_comb begin
    p_nxt[0] = d1_mat_r.m[0] * d1_side_r.off_x;
    p_nxt[1] = d1_mat_r.m[1] * d1_side_r.off_y;
    p_nxt[2] = d1_mat_r.m[3] * d1_side_r.off_x;
    p_nxt[3] = d1_mat_r.m[4] * d1_side_r.off_y;
  end

  // The z row is plus or minus one on the diagonal, so its offset passes without rounding, only saturated to 32 bits.
  always_comb begin
    acc0 = 65'(p_r[0]) + 65'(p_r[1]);
    acc1 = 65'(p_r[2]) + 65'(p_r[3]);
    rnd0 = (acc0 + 65'sd536870912) >>> 30;
    rnd1 = (acc1 + 65'sd536870912) >>> 30;
    d3_nxt      = d2_mat_r;
    d3_nxt.t[0] = sat32(rnd0 + 65'(d2_side_r.pos_x));
    d3_nxt.t[1] = sat32(rnd1 + 65'(d2_side_r.pos_y));
    d3_nxt.t[2] = sat32(d2_side_r.bottom ? -65'(d2_side_r.off_z) : 65'(d2_side_r.off_z));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_valid_r <= 1'b0;
      d2_valid_r <= 1'b0;
      d3_valid_r <= 1'b0;
    end else begin
      d1_valid_r <= cv[CORDIC_STAGES];
      d2_valid_r <= d1_valid_r;
      d3_valid_r <= d2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    d1_mat_r  <= d1_nxt;
    d1_side_r <= cs[CORDIC_STAGES];
    p_r       <= p_nxt;
    d2_mat_r  <= d1_mat_r;
    d2_side_r <= d1_side_r;
    d3_mat_r  <= d3_nxt;
  end

  // Roll, pitch and yaw rotations applied on the right.
  logic     rv [4];
  ptc_mat_t rm [4];

  assign rv[0] = d3_valid_r;
  assign rm[0] = d3_mat_r;

  ptc_col_rot #(.COL_A(1), .COL_B(2), .LANE(0), .NEG_S(1'b0)) u_rot_roll (
    .clk(clk), .rst_n(rst_n), .in_valid(rv[0]), .in_mat(rm[0]),
    .out_valid(rv[1]), .out_mat(rm[1])
  );

  ptc_col_rot #(.COL_A(0), .COL_B(2), .LANE(1), .NEG_S(1'b1)) u_rot_pitch (
    .clk(clk), .rst_n(rst_n), .in_valid(rv[1]), .in_mat(rm[1]),
    .out_valid(rv[2]), .out_mat(rm[2])
  );

  ptc_col_rot #(.COL_A(0), .COL_B(1), .LANE(2), .NEG_S(1'b0)) u_rot_yaw (
    .clk(clk), .rst_n(rst_n), .in_valid(rv[2]), .in_mat(rm[2]),
    .out_valid(rv[3]), .out_mat(rm[3])
  );

  assign out_valid  = rv[3];
  assign out_m_r1c1 = rm[3].m[0];
  assign out_m_r1c2 = rm[3].m[1];
  assign out_m_r1c3 = rm[3].m[2];
  assign out_m_r1c4 = rm[3].t[0];
  assign out_m_r2c1 = rm[3].m[3];
  assign out_m_r2c2 = rm[3].m[4];
  assign out_m_r2c3 = rm[3].m[5];
  assign out_m_r2c4 = rm[3].t[1];
  assign out_m_r3c1 = rm[3].m[6];
  assign out_m_r3c2 = rm[3].m[7];
  assign out_m_r3c3 = rm[3].m[8];
  assign out_m_r3c4 = rm[3].t[2];

endmodule
